>>> sv/indexed_list_engine_unit_defines.svh
// Assertion macros shared by the indexed list engine RTL.
`ifndef INDEXED_LIST_ENGINE_UNIT_DEFINES_SVH
`define INDEXED_LIST_ENGINE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ILE_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ILE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/ile_pkg.sv
// Types and constants of the indexed list engine.
`timescale 1ns / 1ps

package ile_pkg;

   localparam int DEPTH   = 64;
   localparam int ADDR_W  = 6;   // bits to address DEPTH entries
   localparam int COUNT_W = 7;   // bits to hold 0 .. DEPTH
   localparam int DATA_W  = 32;

   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [COUNT_W-1:0] count_type;

   localparam count_type COUNT_FULL = COUNT_W'(DEPTH);

   typedef enum logic [3:0] {
      CMD_INS_FRONT = 4'd0,
      CMD_INS_BACK  = 4'd1,
      CMD_INS_AT    = 4'd2,
      CMD_RM_FRONT  = 4'd3,
      CMD_RM_BACK   = 4'd4,
      CMD_RM_AT     = 4'd5,
      CMD_READ      = 4'd6,
      CMD_WRITE     = 4'd7,
      CMD_CLEAR     = 4'd8
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_BADIDX = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef struct packed {
      logic [3:0]               cmd;
      logic [COUNT_W-1:0]       index;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [1:0]               status;
      logic [COUNT_W-1:0]       count;
   } rsp_type;

endpackage

>>> sv/indexed_list_engine_unit.sv
// Indexed list engine: ordered list of signed words with positional commands.
`timescale 1ns / 1ps
//
// Usage
//  - Command channel: drive req_word and raise start; the word is taken at a
//    rising edge where start is high and busy is low.
//  - Result channel: exactly one result word per command, shown on rsp_word
//    for one cycle with rsp_valid high. The receiver cannot stall it.
// Result path (command taken to rsp_valid high)
//  - error results, write, clear, unused codes: result registered from idle
//  - read: idle, then S_RD_RESP with the RAM data
//  - insert/remove at the tail: idle, then S_FINAL
//  - insert/remove with a shift: idle, S_SHIFT over N entries moved (max 63), S_FINAL
//  - busy drops in the cycle rsp_valid rises, so the next command can be
//    taken while the result is still on the ports.
// A new command is taken only once busy is low again after the last one. A shift
// is bound by the element RAM moving one entry per cycle: one address is read
// while the word read the cycle before is written one place over.
// Reset: synchronous, active high; count goes to zero, the sequencer to idle.
// RAM contents are not cleared; only positions below count are ever read.
//
module indexed_list_engine_unit (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  ile_pkg::req_type req_word,
   output logic            rsp_valid,
   output ile_pkg::rsp_type rsp_word
);

`include "indexed_list_engine_unit_defines.svh"

   typedef enum logic [1:0] {
      S_IDLE,
      S_SHIFT,
      S_FINAL,
      S_RD_RESP
   } state_type;

   // sequencer state
   state_type                  state_ff, state_in;
   ile_pkg::addr_type          ptr_ff, ptr_in;        // next read address
   ile_pkg::addr_type          last_ff, last_in;      // last read address
   ile_pkg::addr_type          pos_ff, pos_in;        // insert position
   logic signed [31:0]         val_ff, val_in;
   logic                       ins_ff, ins_in;        // 1 insert, 0 remove
   logic                       rd_act_ff, rd_act_in;
   logic                       wr_pend_ff, wr_pend_in;
   ile_pkg::addr_type          wr_addr_ff, wr_addr_in;
   ile_pkg::count_type         count_ff, count_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   ile_pkg::rsp_type           rsp_word_ff, rsp_word_in;

   // element RAM
   logic signed [31:0]         mem [ile_pkg::DEPTH];
   logic signed [31:0]         rd_data_ff;
   logic                       mem_we;
   ile_pkg::addr_type          mem_wa, mem_ra;
   logic signed [31:0]         mem_wd;

   ile_pkg::count_type         pos_sel;
   ile_pkg::count_type         count_m1;

   assign count_m1 = count_ff - ile_pkg::COUNT_W'(1);

   // position chosen by the command
   always_comb begin
      case (req_word.cmd) inside
         ile_pkg::CMD_INS_BACK: pos_sel = count_ff;
         ile_pkg::CMD_RM_BACK:  pos_sel = count_m1;
         ile_pkg::CMD_INS_AT, ile_pkg::CMD_RM_AT,
         ile_pkg::CMD_READ, ile_pkg::CMD_WRITE: pos_sel = req_word.index;
         default:               pos_sel = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      last_in      = last_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      ins_in       = ins_ff;
      rd_act_in    = rd_act_ff;
      wr_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = rsp_word_ff;
      mem_we       = 1'b0;
      mem_wa       = wr_addr_ff;
      mem_wd       = rd_data_ff;
      mem_ra       = ptr_ff;

      unique case (state_ff)
         S_IDLE: begin
            mem_ra = req_word.index[ile_pkg::ADDR_W-1:0];
            if (start) begin
               rsp_word_in.read_value = '0;
               rsp_word_in.status     = ile_pkg::ST_OK;
               rsp_word_in.count      = count_ff;
               rsp_valid_in           = 1'b1;
               case (req_word.cmd) inside
                  ile_pkg::CMD_INS_FRONT, ile_pkg::CMD_INS_BACK,
                  ile_pkg::CMD_INS_AT: begin
                     if (count_ff == ile_pkg::COUNT_FULL) begin
                        rsp_word_in.status = ile_pkg::ST_FULL;
                     end else if (pos_sel > count_ff) begin
                        rsp_word_in.status = ile_pkg::ST_BADIDX;
                     end else begin
                        rsp_valid_in = 1'b0;
                        ins_in       = 1'b1;
                        pos_in       = pos_sel[ile_pkg::ADDR_W-1:0];
                        val_in       = req_word.value;
                        ptr_in       = count_m1[ile_pkg::ADDR_W-1:0];
                        last_in      = pos_sel[ile_pkg::ADDR_W-1:0];
                        rd_act_in    = 1'b1;
                        // appending at the tail needs no shift
                        state_in     = (pos_sel == count_ff) ? S_FINAL : S_SHIFT;
                     end
                  end
                  ile_pkg::CMD_RM_FRONT, ile_pkg::CMD_RM_BACK,
                  ile_pkg::CMD_RM_AT: begin
                     if (count_ff == '0) begin
                        rsp_word_in.status = ile_pkg::ST_EMPTY;
                     end else if (pos_sel >= count_ff) begin
                        rsp_word_in.status = ile_pkg::ST_BADIDX;
                     end else begin
                        rsp_valid_in = 1'b0;
                        ins_in       = 1'b0;
                        ptr_in       = pos_sel[ile_pkg::ADDR_W-1:0]
                                       + ile_pkg::ADDR_W'(1);
                        last_in      = count_m1[ile_pkg::ADDR_W-1:0];
                        rd_act_in    = 1'b1;
                        // dropping the tail needs no shift
                        state_in     = (pos_sel == count_m1) ? S_FINAL : S_SHIFT;
                     end
                  end
                  ile_pkg::CMD_READ, ile_pkg::CMD_WRITE: begin
                     if (count_ff == '0) begin
                        rsp_word_in.status = ile_pkg::ST_EMPTY;
                     end else if (req_word.index >= count_ff) begin
                        rsp_word_in.status = ile_pkg::ST_BADIDX;
                     end else if (req_word.cmd == ile_pkg::CMD_READ) begin
                        // RAM read issued this cycle, data next cycle
                        rsp_valid_in = 1'b0;
                        state_in     = S_RD_RESP;
                     end else begin
                        mem_we = 1'b1;
                        mem_wa = req_word.index[ile_pkg::ADDR_W-1:0];
                        mem_wd = req_word.value;
                     end
                  end
                  ile_pkg::CMD_CLEAR: begin
                     count_in          = '0;
                     rsp_word_in.count = '0;
                  end
                  default: ;
               endcase
            end
         end

         S_SHIFT: begin
            // write back the word read last cycle while reading the next
            mem_we = wr_pend_ff;
            if (rd_act_ff) begin
               wr_pend_in = 1'b1;
               wr_addr_in = ins_ff ? (ptr_ff + ile_pkg::ADDR_W'(1))
                                   : (ptr_ff - ile_pkg::ADDR_W'(1));
               if (ptr_ff == last_ff) begin
                  rd_act_in = 1'b0;
               end else begin
                  ptr_in = ins_ff ? (ptr_ff - ile_pkg::ADDR_W'(1))
                                  : (ptr_ff + ile_pkg::ADDR_W'(1));
               end
            end else if (wr_pend_ff) begin
               state_in = S_FINAL;
            end
         end

         S_FINAL: begin
            if (ins_ff) begin
               mem_we   = 1'b1;
               mem_wa   = pos_ff;
               mem_wd   = val_ff;
               count_in = count_ff + ile_pkg::COUNT_W'(1);
            end else begin
               count_in = count_m1;
            end
            rsp_word_in.read_value = '0;
            rsp_word_in.status     = ile_pkg::ST_OK;
            rsp_word_in.count      = count_in;
            rsp_valid_in           = 1'b1;
            state_in               = S_IDLE;
         end

         S_RD_RESP: begin
            rsp_word_in.read_value = rd_data_ff;
            rsp_word_in.status     = ile_pkg::ST_OK;
            rsp_word_in.count      = count_ff;
            rsp_valid_in           = 1'b1;
            state_in               = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_act_ff    <= 1'b0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_act_ff    <= rd_act_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         ptr_ff       <= ptr_in;
         last_ff      <= last_in;
         pos_ff       <= pos_in;
         val_ff       <= val_in;
         ins_ff       <= ins_in;
         wr_addr_ff   <= wr_addr_in;
         rsp_word_ff  <= rsp_word_in;
      end
   end

   // element RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `ILE_ASSERT_SAME(a_count_bound, clock, reset, 1'b1,
                    count_ff <= ile_pkg::COUNT_FULL, "count above depth")
   `ILE_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy,
                    rsp_valid || busy, "command dropped")
   `ILE_ASSERT_SAME(a_rsp_idle, clock, reset, rsp_valid, !busy, "result shown while busy")
   `ILE_ASSERT_SAME(a_full_count, clock, reset,
                    rsp_valid && (rsp_word.status == ile_pkg::ST_FULL),
                    rsp_word.count == ile_pkg::COUNT_FULL, "full status on list not full")

endmodule

>>> verif/indexed_list_engine_unit_checker.sv
// Checker for the indexed list engine: list predictor and result scoreboard.
`timescale 1ns / 1ps

module indexed_list_engine_unit_checker
   import ile_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_word,
   input  logic    rsp_valid,
   input  rsp_type rsp_word,
   output int      fail_count,
   output int      pending,
   output int      results_checked,
   output int      full_rejects,
   output int      empty_rejects
);

   localparam int SHOW_LIMIT = 10;

   // shadow copy of the list
   logic signed [DATA_W-1:0] list_mem [DEPTH];
   int unsigned              list_len;

   rsp_type awaited_results [$];

   function automatic rsp_type predict_list_result(input req_type w);
      rsp_type     r;
      int unsigned pos;
      logic        do_ins;
      logic        do_rm;
      r      = '0;
      pos    = 0;
      do_ins = 1'b0;
      do_rm  = 1'b0;
      r.status = ST_OK;
      case (w.cmd)
         CMD_INS_FRONT: begin
            do_ins = 1'b1;
         end
         CMD_INS_BACK: begin
            do_ins = 1'b1;
            pos    = list_len;
         end
         CMD_INS_AT: begin
            do_ins = 1'b1;
            pos    = 32'(w.index);
         end
         CMD_RM_FRONT: begin
            do_rm = 1'b1;
         end
         CMD_RM_BACK: begin
            do_rm = 1'b1;
            pos   = (list_len == 0) ? 0 : list_len - 1;
         end
         CMD_RM_AT: begin
            do_rm = 1'b1;
            pos   = 32'(w.index);
         end
         CMD_READ: begin
            if (list_len == 0) r.status = ST_EMPTY;
            else if (w.index >= list_len) r.status = ST_BADIDX;
            else r.read_value = list_mem[w.index];
         end
         CMD_WRITE: begin
            if (list_len == 0) r.status = ST_EMPTY;
            else if (w.index >= list_len) r.status = ST_BADIDX;
            else list_mem[w.index] = w.value;
         end
         CMD_CLEAR: begin
            list_len = 0;
         end
         default: ;
      endcase

      // full check wins over the index check
      if (do_ins) begin
         if (list_len >= DEPTH) r.status = ST_FULL;
         else if (pos > list_len) r.status = ST_BADIDX;
         else begin
            for (int unsigned i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
            list_mem[pos] = w.value;
            list_len++;
         end
      end
      if (do_rm) begin
         if (list_len == 0) r.status = ST_EMPTY;
         else if (pos >= list_len) r.status = ST_BADIDX;
         else begin
            for (int unsigned i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
            list_len--;
         end
      end
      r.count = COUNT_W'(list_len);
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] want,
                                input logic [DATA_W-1:0] got);
      fail_count++;
      if (fail_count <= SHOW_LIMIT)
         $display("MISMATCH %0d at %0t: %s expected %0h got %0h",
                  fail_count, $realtime, what, want, got);
   endtask

   initial begin
      fail_count      = 0;
      pending         = 0;
      results_checked = 0;
      full_rejects    = 0;
      empty_rejects   = 0;
      list_len        = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      rsp_type fresh;
      if (reset) begin
         list_len = 0;
         awaited_results.delete();
      end else begin
         if (rsp_valid) begin
            if (awaited_results.size() == 0) begin
               flag_mismatch("result word with nothing outstanding", '0,
                             rsp_word.read_value);
            end else begin
               want = awaited_results.pop_front();
               results_checked++;
               if (rsp_word.read_value !== want.read_value)
                  flag_mismatch("read_value", want.read_value, rsp_word.read_value);
               if (rsp_word.status !== want.status)
                  flag_mismatch("status", DATA_W'(want.status), DATA_W'(rsp_word.status));
               if (rsp_word.count !== want.count)
                  flag_mismatch("count", DATA_W'(want.count), DATA_W'(rsp_word.count));
            end
         end
         if (start && !busy) begin
            fresh = predict_list_result(req_word);
            if (fresh.status == ST_FULL) full_rejects++;
            if (fresh.status == ST_EMPTY) empty_rejects++;
            awaited_results.push_back(fresh);
         end
      end
      pending <= awaited_results.size();
   end

endmodule

>>> verif/indexed_list_engine_unit_tb.sv
// Testbench top for the indexed list engine: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps

module indexed_list_engine_unit_tb;
   import ile_pkg::*;

   localparam int RANDOM_BLOCKS = 16;
   localparam int BLOCK_WORDS   = 125;     // 16 x 125 = 2000 random words
   localparam int MAX_GAP       = 5;
   localparam int DRAIN_CYCLES  = 80;      // margin after the longest shift (63 entries moved)
   localparam int CYCLE_LIMIT   = 1000000;

   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

   // codes past clear are unused and must act as no-ops
   localparam logic [3:0] CMD_FIRST_UNUSED = 4'(CMD_CLEAR) + 4'd1;
   localparam logic [3:0] CMD_LAST_CODE    = 4'hF;

   typedef enum logic [1:0] {MODE_GROW, MODE_SHRINK, MODE_MIX} list_mode_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_word;
   logic    rsp_valid;
   rsp_type rsp_word;

   int fail_count;
   int pending;
   int results_checked;
   int full_rejects;
   int empty_rejects;

   int            words_sent;
   int            cycle_count;
   logic          gaps_on;
   int unsigned   seen_count;      // last count the block reported, steers indexes
   list_mode_type list_mode;

   indexed_list_engine_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   // scoreboard sits beside the block and only watches the two channels
   indexed_list_engine_unit_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_word        (req_word),
      .rsp_valid       (rsp_valid),
      .rsp_word        (rsp_word),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_checked (results_checked),
      .full_rejects    (full_rejects),
      .empty_rejects   (empty_rejects)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: any hang ends the run as a failure
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // track the list length as the block reports it; only biases stimulus
   always @(posedge clock) begin
      if (reset) seen_count <= 0;
      else if (rsp_valid) seen_count <= rsp_word.count;
   end

   // One command word. Optional idle gap first, then hold start until the
   // word is taken (start high and busy low at an edge). When no gap is drawn,
   // start stays high straight into the next word: no low/high in one step.
   task automatic send_word(input logic [3:0] cmd, input logic [COUNT_W-1:0] idx,
                            input logic signed [DATA_W-1:0] val);
      int gap;
      gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_word.cmd   <= cmd;
      req_word.index <= idx;
      req_word.value <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
      words_sent++;
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return VAL_MAX;
         1:       return VAL_MIN;
         2:       return '0;
         3:       return -1;
         default: return $urandom;
      endcase
   endfunction

   // mostly legal positions, the boundary often, anything now and then
   function automatic logic [COUNT_W-1:0] pick_index();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 7) return COUNT_W'($urandom_range(0, seen_count));
      if (r < 9) return COUNT_W'(seen_count);
      return COUNT_W'($urandom_range(0, DEPTH));
   endfunction

   // weights shift with the phase so the list swings between empty and full
   function automatic logic [3:0] pick_cmd(input list_mode_type mode);
      int unsigned r;
      int unsigned ins_w;
      int unsigned rm_w;
      r     = $urandom_range(0, 99);
      ins_w = (mode == MODE_GROW) ? 65 : (mode == MODE_SHRINK) ? 15 : 35;
      rm_w  = (mode == MODE_GROW) ? 15 : (mode == MODE_SHRINK) ? 65 : 35;
      if (r < ins_w) begin
         case ($urandom_range(0, 2))
            0:       return CMD_INS_FRONT;
            1:       return CMD_INS_BACK;
            default: return CMD_INS_AT;
         endcase
      end
      if (r < ins_w + rm_w) begin
         case ($urandom_range(0, 2))
            0:       return CMD_RM_FRONT;
            1:       return CMD_RM_BACK;
            default: return CMD_RM_AT;
         endcase
      end
      r = r - ins_w - rm_w;
      if (r < 9) return CMD_READ;
      if (r < 18) return CMD_WRITE;
      if (r == 18) return (mode == MODE_MIX) ? CMD_CLEAR : CMD_READ;
      return 4'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE));
   endfunction

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_word    = '0;
      words_sent  = 0;
      gaps_on     = 1'b1;
      list_mode   = MODE_GROW;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // --- directed: reads, writes and removals on an empty list first
      send_word(CMD_READ,     0, '0);
      send_word(CMD_RM_FRONT, 0, '0);
      send_word(CMD_RM_BACK,  0, '0);
      send_word(CMD_RM_AT,    0, '0);
      send_word(CMD_WRITE,    0, VAL_MAX);
      // build [max, -1, min, 0]; index past count is rejected, index == count appends
      send_word(CMD_INS_FRONT, 0, VAL_MAX);
      send_word(CMD_INS_BACK,  0, VAL_MIN);
      send_word(CMD_INS_AT,    1, -1);
      send_word(CMD_INS_AT,    5, 32'sh1234_5678);
      send_word(CMD_INS_AT,    3, '0);
      // reads at both ends, a write in the middle, and reads and writes out of range
      send_word(CMD_READ,  0, '0);
      send_word(CMD_READ,  3, '0);
      send_word(CMD_READ,  4, '0);
      send_word(CMD_READ,  COUNT_W'(DEPTH), '0);
      send_word(CMD_WRITE, 2, 32'sh5555_5555);
      send_word(CMD_WRITE, COUNT_W'(DEPTH), 32'shAAAA_AAAA);
      send_word(CMD_READ,  2, '0);
      // removals: middle, past the end, both ends
      send_word(CMD_RM_AT,    1, '0);
      send_word(CMD_RM_AT,    3, '0);
      send_word(CMD_RM_FRONT, 0, '0);
      send_word(CMD_RM_BACK,  0, '0);
      // unused codes leave the list alone
      send_word(CMD_FIRST_UNUSED, COUNT_W'(DEPTH), VAL_MIN);
      send_word(CMD_LAST_CODE,    0, VAL_MAX);
      send_word(CMD_CLEAR,        0, '0);

      // --- random: phases grow the list to full, churn it, then drain it
      for (int b = 0; b < RANDOM_BLOCKS; b++) begin
         case (b % 4)
            0:       list_mode = MODE_GROW;
            2:       list_mode = MODE_SHRINK;
            default: list_mode = MODE_MIX;
         endcase
         gaps_on = ($urandom_range(0, 3) != 0);   // some phases run back to back
         for (int n = 0; n < BLOCK_WORDS; n++)
            send_word(pick_cmd(list_mode), pick_index(), pick_value());
      end
      start <= 1'b0;

      // drain: one edge so the last push is visible, then wait out results
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d command words, checked %0d results, %0d mismatches",
               words_sent, results_checked, fail_count);
      $display("Inserts refused on a full list: %0d, commands on an empty list: %0d",
               full_rejects, empty_rejects);
      if (fail_count == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
